// ===== rtl/fdf_pkg.sv =====
package fdf_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 2;

    localparam logic [3:0]  COUNT_LIMIT   = 4'd13;
    localparam logic [15:0] BROADCAST_PAN = 16'hFFFF;
    localparam logic [15:0] ACK_REQ_MASK  = 16'h0020;
    localparam logic [15:0] DST_MODE_MASK = 16'h0C00;
    localparam logic [15:0] SRC_MODE_MASK = 16'hC000;
    localparam logic [15:0] TYPE_MASK     = 16'h0007;
    localparam logic [15:0] TYPE_ACK      = 16'h0002;
    localparam logic [7:0]  LAST_TX_RESET = 8'hFF;

    // Frame byte positions
    localparam logic [3:0] POS_FCF_LO  = 4'd0;
    localparam logic [3:0] POS_FCF_HI  = 4'd1;
    localparam logic [3:0] POS_SEQ     = 4'd2;
    localparam logic [3:0] POS_PAN_LO  = 4'd3;
    localparam logic [3:0] POS_PAN_HI  = 4'd4;
    localparam logic [3:0] POS_ADDR_LO = 4'd5;

    // Minimum lengths for the address checks
    localparam logic [3:0] LEN_MIN_FRAME = 4'd3;
    localparam logic [3:0] LEN_PAN       = 4'd5;
    localparam logic [3:0] LEN_SHORT     = 4'd7;
    localparam logic [3:0] LEN_EXT       = 4'd13;

    typedef enum logic [1:0] {
        CFG_OWN_PAN   = 2'd0,
        CFG_OWN_SHORT = 2'd1,
        CFG_OWN_EXT   = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_RESERVED = 2'd1,
        MODE_SHORT    = 2'd2,
        MODE_EXT      = 2'd3
    } t_addr_mode;

    // Snapshot of one finished frame, handed from front to back
    typedef struct packed {
        logic [3:0]  len;
        logic [15:0] fcf;
        logic [7:0]  seq;
        logic [15:0] pan;
        logic [63:0] ext;      // low 16 bits double as the short address
        logic [7:0]  last_tx;
    } t_frame_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== rtl/fdf_front.sv =====
module fdf_front
    import fdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic       i_func,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_push,
    output t_frame_rec o_rec
);

    logic [3:0]  r_count, n_count;
    logic [15:0] r_fcf, n_fcf;
    logic [7:0]  r_seq, n_seq;
    logic [15:0] r_pan, n_pan;
    logic [63:0] r_ext, n_ext;
    logic [7:0]  r_last_tx;
    logic [2:0]  ext_idx;
    logic        frame_byte;

    assign frame_byte = i_fire && !i_func;
    assign ext_idx    = 3'(r_count - POS_ADDR_LO);

    always_comb begin
        n_count = r_count;
        n_fcf   = r_fcf;
        n_seq   = r_seq;
        n_pan   = r_pan;
        n_ext   = r_ext;
        if (frame_byte && r_count < COUNT_LIMIT) begin
            n_count = r_count + 4'd1;
            unique case (r_count)
                POS_FCF_LO: n_fcf[7:0]  = i_data_byte;
                POS_FCF_HI: n_fcf[15:8] = i_data_byte;
                POS_SEQ:    n_seq       = i_data_byte;
                POS_PAN_LO: n_pan[7:0]  = i_data_byte;
                POS_PAN_HI: n_pan[15:8] = i_data_byte;
                default:    n_ext[{ext_idx, 3'b000} +: 8] = i_data_byte;
            endcase
        end
    end

    assign o_push        = frame_byte && i_last_byte;
    assign o_rec.len     = n_count;
    assign o_rec.fcf     = n_fcf;
    assign o_rec.seq     = n_seq;
    assign o_rec.pan     = n_pan;
    assign o_rec.ext     = n_ext;
    assign o_rec.last_tx = r_last_tx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_fcf     <= '0;
            r_seq     <= '0;
            r_pan     <= '0;
            r_ext     <= '0;
            r_last_tx <= LAST_TX_RESET;
        end else begin
            if (i_fire && i_func) begin
                r_last_tx <= i_data_byte;
            end
            if (o_push) begin
                r_count <= '0;
                r_fcf   <= '0;
                r_seq   <= '0;
                r_pan   <= '0;
                r_ext   <= '0;
            end else begin
                r_count <= n_count;
                r_fcf   <= n_fcf;
                r_seq   <= n_seq;
                r_pan   <= n_pan;
                r_ext   <= n_ext;
            end
        end
    end

endmodule

// ===== rtl/fdf_queue.sv =====
module fdf_queue
    import fdf_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_rec i_rec,
    input  logic       i_pop,
    output t_frame_rec o_rec,
    output t_q_status  o_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_frame_rec             r_mem [DEPTH];
    logic [PTR_W-1:0]       r_wr, r_rd;
    logic [CNT_W-1:0]       r_cnt;
    logic                   do_push, do_pop;

    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_rec          = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/fdf_back.sv =====
module fdf_back
    import fdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_frame_rec  i_rec,
    input  t_q_status   i_q_status,
    output logic        o_pop,
    input  logic [15:0] i_own_pan,
    input  logic [15:0] i_own_short,
    input  logic [63:0] i_own_ext,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_accept,
    output logic        o_is_ack,
    output logic        o_ack_matches,
    output logic        o_send_ack,
    output logic [7:0]  o_frame_sequence
);

    logic       r_valid;
    logic       r_accept, r_is_ack, r_match, r_send;
    logic [7:0] r_seq;
    logic       is_ack, acc, pan_hit;
    t_addr_mode dmode;
    t_addr_mode smode;

    assign is_ack  = (i_rec.fcf & TYPE_MASK) == TYPE_ACK;
    assign dmode   = t_addr_mode'(i_rec.fcf[11:10]);
    assign smode   = t_addr_mode'(i_rec.fcf[15:14]);
    assign pan_hit = (i_rec.pan == BROADCAST_PAN) || (i_rec.pan == i_own_pan);

    always_comb begin
        acc = 1'b0;
        if (i_rec.len < LEN_MIN_FRAME) begin
            acc = 1'b0;
        end else if (is_ack) begin
            acc = (i_rec.len == LEN_MIN_FRAME) && (dmode == MODE_NONE) && (smode == MODE_NONE);
        end else begin
            unique case (dmode)
                MODE_NONE:     acc = 1'b1;
                MODE_RESERVED: acc = 1'b0;
                MODE_SHORT:    acc = (i_rec.len >= LEN_PAN) &&
                                     (pan_hit || ((i_rec.len >= LEN_SHORT) &&
                                      (i_rec.ext[15:0] == i_own_short)));
                MODE_EXT:      acc = (i_rec.len >= LEN_PAN) &&
                                     (pan_hit || ((i_rec.len >= LEN_EXT) &&
                                      (i_rec.ext == i_own_ext)));
                default:       acc = 1'b0;
            endcase
        end
    end

    assign o_pop = !i_q_status.empty && (!r_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_accept <= acc;
            r_is_ack <= is_ack;
            r_match  <= acc && is_ack && (i_rec.seq == i_rec.last_tx);
            r_send   <= acc && !is_ack && ((i_rec.fcf & ACK_REQ_MASK) != '0);
            r_seq    <= i_rec.seq;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_accept         = r_accept;
    assign o_is_ack         = r_is_ack;
    assign o_ack_matches    = r_match;
    assign o_send_ack       = r_send;
    assign o_frame_sequence = r_seq;

endmodule

// ===== rtl/frame_destination_filter_unit.sv =====
// Destination filter for received 802.15.4 frames.
//
// Input channel: one item per accepted cycle (i_in_valid high, o_in_stall low).
// With i_in_func = 0 the item is a frame byte; i_in_last_byte marks the final
// byte. With i_in_func = 1 the byte is recorded as the sequence number of the
// last transmitted frame; such an item leaves the frame in progress alone.
// Output channel: one result item per frame, taken when o_out_valid is high
// and i_out_stall is low.
// Throughput: one byte per cycle while the frame queue is not full, also while
// a result waits. The final byte of a frame writes the frame into the queue;
// the compare result is then loaded into the result register when the back
// pops the frame from the queue head.
// When the receiver stalls, the result register holds and the frame queue
// fills; o_in_stall rises only once the queue holds QUEUE_DEPTH frames.
// Reset (synchronous, active low) clears the frame, the queue and the result
// register, and sets the own addresses to their defaults and the recorded
// transmit sequence to 0xFF. Configuration writes take effect at once. They are
// to be made while no frame is in flight; the block does not enforce this.
module frame_destination_filter_unit
    import fdf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_in_func,
    input  logic [7:0]  i_in_data_byte,
    input  logic        i_in_last_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_out_accept,
    output logic        o_out_is_ack_frame,
    output logic        o_out_ack_matches,
    output logic        o_out_send_ack,
    output logic [7:0]  o_out_frame_sequence,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [15:0] r_own_pan;
    logic [15:0] r_own_short;
    logic [63:0] r_own_ext;

    logic        in_fire;
    logic        push;
    logic        pop;
    t_frame_rec  push_rec;
    t_frame_rec  head_rec;
    t_q_status   q_status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_pan   <= BROADCAST_PAN;
            r_own_short <= 16'hFFFF;
            r_own_ext   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OWN_PAN:   r_own_pan   <= i_cfg_data[15:0];
                CFG_OWN_SHORT: r_own_short <= i_cfg_data[15:0];
                CFG_OWN_EXT:   r_own_ext   <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Hold the input while the queue is full
    assign o_in_stall = q_status.full;
    assign in_fire    = i_in_valid && !o_in_stall;

    // Front: assemble frame fields, snapshot them on the final byte
    fdf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_fire),
        .i_func      (i_in_func),
        .i_data_byte (i_in_data_byte),
        .i_last_byte (i_in_last_byte),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    // Queue of finished frames between front and back
    fdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (push_rec),
        .i_pop    (pop),
        .o_rec    (head_rec),
        .o_status (q_status)
    );

    // Back: run the address compare and drive the result register
    fdf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rec            (head_rec),
        .i_q_status       (q_status),
        .o_pop            (pop),
        .i_own_pan        (r_own_pan),
        .i_own_short      (r_own_short),
        .i_own_ext        (r_own_ext),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_accept         (o_out_accept),
        .o_is_ack         (o_out_is_ack_frame),
        .o_ack_matches    (o_out_ack_matches),
        .o_send_ack       (o_out_send_ack),
        .o_frame_sequence (o_out_frame_sequence)
    );

endmodule

// ===== rtl/fdf_checker.sv =====
module fdf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_out_accept,
    input logic       o_out_is_ack_frame,
    input logic       o_out_ack_matches,
    input logic       o_out_send_ack,
    input logic [7:0] o_out_frame_sequence
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_accept) &&
            $stable(o_out_ack_matches) && $stable(o_out_send_ack) &&
            $stable(o_out_frame_sequence) && $stable(o_out_is_ack_frame))
        else $error("stalled result changed");

    // Reset empties the result register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // An ack match needs an accepted ack frame
    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_ack_matches |-> o_out_accept && o_out_is_ack_frame)
        else $error("ack match on rejected or non-ack frame");

    // An ack request needs an accepted non-ack frame
    a_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_send_ack |-> o_out_accept && !o_out_is_ack_frame)
        else $error("send ack on rejected or ack frame");

endmodule

bind frame_destination_filter_unit fdf_checker u_fdf_checker (.*);

// ===== dv/tb_frame_destination_filter_unit.sv =====
module tb_frame_destination_filter_unit import fdf_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Item kinds on the input channel
    localparam logic FUNC_RX_BYTE = 1'b0;
    localparam logic FUNC_TX_SEQ  = 1'b1;

    localparam int unsigned CLK_HALF      = 5;
    localparam int unsigned RESET_CYCLES  = 10;
    localparam int unsigned SETTLE_CYCLES = 6;      // margin after the last result
    localparam int unsigned HOLD_CYCLES   = 150;    // long receiver hold-off
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned PHASE_ITEMS   = 85;
    localparam int unsigned NUM_PHASES    = 5;
    localparam int unsigned HDR_BYTES     = 13;
    localparam int unsigned RUN_LIMIT_NS  = 2000000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    typedef struct packed {
        logic       accept;
        logic       is_ack_frame;
        logic       ack_matches;
        logic       send_ack;
        logic [7:0] frame_sequence;
    } t_frame_verdict;

    typedef logic [7:0] t_byte_q[$];

    // Tracks the frame being received and queues the verdict of every
    // finished frame until the block delivers it.
    class frame_filter_scoreboard;
        logic [15:0] own_pan;
        logic [15:0] own_short;
        logic [63:0] own_ext;
        logic [3:0]  byte_count;
        logic [15:0] fcf;
        logic [7:0]  seq_byte;
        logic [15:0] dest_pan;
        logic [63:0] dest_addr;     // low 16 bits hold the short address
        logic [7:0]  last_tx_seq;
        t_frame_verdict verdicts[$];
        int unsigned n_errors;
        int unsigned n_results;
        int unsigned n_accepted;
        int unsigned n_matched;
        int unsigned n_ack_requests;

        function new();
            own_pan        = 16'hFFFF;
            own_short      = 16'hFFFF;
            own_ext        = '0;
            last_tx_seq    = LAST_TX_RESET;
            n_errors       = 0;
            n_results      = 0;
            n_accepted     = 0;
            n_matched      = 0;
            n_ack_requests = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_count = '0;
            fcf        = '0;
            seq_byte   = '0;
            dest_pan   = '0;
            dest_addr  = '0;
        endfunction

        function void set_register(t_cfg_index idx, logic [63:0] value);
            case (idx)
                CFG_OWN_PAN:   own_pan   = value[15:0];
                CFG_OWN_SHORT: own_short = value[15:0];
                CFG_OWN_EXT:   own_ext   = value;
                default: ;
            endcase
        endfunction

        function bit passes_filter(logic is_ack);
            t_addr_mode dmode;
            t_addr_mode smode;
            dmode = t_addr_mode'(fcf[11:10]);
            smode = t_addr_mode'(fcf[15:14]);
            if (byte_count < LEN_MIN_FRAME) return 1'b0;
            // acks carry no addresses and nothing past the sequence number
            if (is_ack)
                return byte_count == LEN_MIN_FRAME && dmode == MODE_NONE && smode == MODE_NONE;
            if (dmode == MODE_NONE) return 1'b1;
            if (dmode == MODE_RESERVED) return 1'b0;
            if (byte_count < LEN_PAN) return 1'b0;
            if (dest_pan == BROADCAST_PAN || dest_pan == own_pan) return 1'b1;
            if (dmode == MODE_SHORT)
                return byte_count >= LEN_SHORT && dest_addr[15:0] == own_short;
            return byte_count >= LEN_EXT && dest_addr == own_ext;
        endfunction

        function void note_item(logic func, logic [7:0] data, logic last);
            t_frame_verdict v;
            if (func == FUNC_TX_SEQ) begin
                last_tx_seq = data;
                return;
            end
            // bytes past the header are counted as the limit and dropped
            if (byte_count < COUNT_LIMIT) begin
                case (byte_count)
                    POS_FCF_LO: fcf[7:0]       = data;
                    POS_FCF_HI: fcf[15:8]      = data;
                    POS_SEQ:    seq_byte       = data;
                    POS_PAN_LO: dest_pan[7:0]  = data;
                    POS_PAN_HI: dest_pan[15:8] = data;
                    default:
                        dest_addr[8 * (int'(byte_count) - int'(POS_ADDR_LO)) +: 8] = data;
                endcase
                byte_count++;
            end
            if (!last) return;
            v.is_ack_frame   = (fcf & TYPE_MASK) == TYPE_ACK;
            v.accept         = passes_filter(v.is_ack_frame);
            v.ack_matches    = v.accept && v.is_ack_frame && seq_byte == last_tx_seq;
            v.send_ack       = v.accept && !v.is_ack_frame && (fcf & ACK_REQ_MASK) != 0;
            v.frame_sequence = seq_byte;
            verdicts.push_back(v);
            clear_frame();
        endfunction

        function void check_result(t_frame_verdict got);
            t_frame_verdict want;
            if (verdicts.size() == 0) begin
                $error("result item with no frame pending: %p", got);
                n_errors++;
                return;
            end
            want = verdicts.pop_front();
            n_results++;
            if (want.accept) n_accepted++;
            if (want.ack_matches) n_matched++;
            if (want.send_ack) n_ack_requests++;
            if (got.accept !== want.accept) begin
                $error("accept: expected %0b, actual %0b", want.accept, got.accept);
                n_errors++;
            end
            if (got.is_ack_frame !== want.is_ack_frame) begin
                $error("is_ack_frame: expected %0b, actual %0b",
                       want.is_ack_frame, got.is_ack_frame);
                n_errors++;
            end
            if (got.ack_matches !== want.ack_matches) begin
                $error("ack_matches: expected %0b, actual %0b",
                       want.ack_matches, got.ack_matches);
                n_errors++;
            end
            if (got.send_ack !== want.send_ack) begin
                $error("send_ack: expected %0b, actual %0b", want.send_ack, got.send_ack);
                n_errors++;
            end
            if (got.frame_sequence !== want.frame_sequence) begin
                $error("frame_sequence: expected 0x%02h, actual 0x%02h",
                       want.frame_sequence, got.frame_sequence);
                n_errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        in_func;
    logic [7:0]  in_data_byte;
    logic        in_last_byte;
    logic        out_valid;
    logic        out_stall;
    logic        out_accept;
    logic        out_is_ack_frame;
    logic        out_ack_matches;
    logic        out_send_ack;
    logic [7:0]  out_frame_sequence;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    frame_filter_scoreboard board;

    // Idling knobs, set by the stimulus and read by the two channel drivers
    t_stall_mode stall_mode;
    bit          gaps_on;
    int unsigned max_gap;
    int unsigned burst_left;
    int unsigned hold_requests;
    int unsigned items_sent;
    int unsigned frames_sent;

    frame_destination_filter_unit i_dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_stall           (in_stall),
        .i_in_func            (in_func),
        .i_in_data_byte       (in_data_byte),
        .i_in_last_byte       (in_last_byte),
        .o_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .o_out_accept         (out_accept),
        .o_out_is_ack_frame   (out_is_ack_frame),
        .o_out_ack_matches    (out_ack_matches),
        .o_out_send_ack       (out_send_ack),
        .o_out_frame_sequence (out_frame_sequence),
        .i_cfg_we             (cfg_we),
        .i_cfg_index          (cfg_index),
        .i_cfg_data           (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Bound the whole run; a hang anywhere ends here.
    initial begin
        #(RUN_LIMIT_NS);
        $error("run exceeded its time limit");
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: stall on the current pattern, or hold off for a long stretch
    // whenever the stimulus asks for one.
    initial begin
        int unsigned hold_left;
        int unsigned hold_served;
        int unsigned tick;
        hold_left   = 0;
        hold_served = 0;
        tick        = 0;
        out_stall   = 1'b0;
        forever begin
            @(negedge clk);
            tick++;
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
                    default:     out_stall <= ((tick % 7) < 3);
                endcase
            end
        end
    end

    // Check every result item the block hands over.
    always @(posedge clk) begin
        t_frame_verdict got;
        if (rst_n && out_valid && !out_stall) begin
            got.accept         = out_accept;
            got.is_ack_frame   = out_is_ack_frame;
            got.ack_matches    = out_ack_matches;
            got.send_ack       = out_send_ack;
            got.frame_sequence = out_frame_sequence;
            board.check_result(got);
        end
    end

    // Offer one item and hold it until the block takes it. Called and
    // returns at a falling edge; valid is left high for a following item.
    task automatic send_item(input logic func, input logic [7:0] data, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on) begin
                gap = $urandom_range(1, max_gap);
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        in_func      <= func;
        in_data_byte <= data;
        in_last_byte <= last;
        do @(posedge clk); while (in_stall);
        board.note_item(func, data, last);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic t_byte_q make_frame(input logic [15:0] fcf, input logic [7:0] seq,
                                           input logic [15:0] pan, input logic [63:0] addr,
                                           input int unsigned len);
        t_byte_q      q;
        logic [103:0] hdr;
        hdr = {addr, pan, seq, fcf};
        for (int i = 0; i < len; i++)
            q.push_back(i < HDR_BYTES ? hdr[8 * i +: 8] : 8'($urandom));
        return q;
    endfunction

    // Send a frame, marking its final byte; optionally slip transmit
    // sequence records in between its bytes.
    task automatic send_frame(input t_byte_q frame, input bit mix_records);
        for (int i = 0; i < frame.size(); i++) begin
            if (mix_records && $urandom_range(0, 19) == 0)
                send_item(FUNC_TX_SEQ, 8'($urandom), 1'($urandom));
            send_item(FUNC_RX_BYTE, frame[i], i == frame.size() - 1);
        end
        frames_sent++;
    endtask

    // Mostly well-formed frames aimed at this node's addresses, with
    // truncated, overlong and mistargeted ones mixed in.
    task automatic send_random_frame();
        logic [15:0]  fcf;
        logic [7:0]   seq;
        logic [15:0]  pan;
        logic [63:0]  addr;
        int unsigned  natural_len;
        int unsigned  len;
        bit           is_ack;
        int unsigned  pick;
        fcf = 16'($urandom);
        if ($urandom_range(0, 4) == 0) fcf[2:0] = TYPE_ACK[2:0];
        is_ack = (fcf & TYPE_MASK) == TYPE_ACK;
        if (is_ack) begin
            if ($urandom_range(0, 3) != 0) begin
                fcf[11:10] = MODE_NONE;
                fcf[15:14] = MODE_NONE;
            end
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 2)      fcf[11:10] = MODE_NONE;
            else if (pick < 3) fcf[11:10] = MODE_RESERVED;
            else if (pick < 6) fcf[11:10] = MODE_SHORT;
            else               fcf[11:10] = MODE_EXT;
        end
        if ($urandom_range(0, 5) == 0)
            send_item(FUNC_TX_SEQ, 8'($urandom), 1'($urandom));
        seq = $urandom_range(0, 1) ? board.last_tx_seq : 8'($urandom);
        case ($urandom_range(0, 2))
            0:       pan = BROADCAST_PAN;
            1:       pan = board.own_pan;
            default: pan = 16'($urandom);
        endcase
        addr = {32'($urandom), 32'($urandom)};
        if ($urandom_range(0, 1)) begin
            if (t_addr_mode'(fcf[11:10]) == MODE_EXT) addr = board.own_ext;
            else addr[15:0] = board.own_short;
            // near miss on one bit
            if ($urandom_range(0, 3) == 0) addr[$urandom_range(0, 63)] ^= 1'b1;
        end
        if (is_ack) natural_len = LEN_MIN_FRAME;
        else case (t_addr_mode'(fcf[11:10]))
            MODE_SHORT: natural_len = LEN_SHORT;
            MODE_EXT:   natural_len = LEN_EXT;
            default:    natural_len = LEN_MIN_FRAME;
        endcase
        if ($urandom_range(0, 9) < 7)
            len = natural_len + (is_ack ? 0 : $urandom_range(0, 3));
        else
            len = $urandom_range(1, 18);
        send_frame(make_frame(fcf, seq, pan, addr, len), 1'b1);
    endtask

    // Drop valid and wait until every frame verdict has been delivered.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.verdicts.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.set_register(idx, value);
        @(negedge clk);
    endtask

    initial begin
        int unsigned phase_end;
        int unsigned drain_cycles;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_func      = FUNC_RX_BYTE;
        in_data_byte = '0;
        in_last_byte = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_OWN_PAN;
        cfg_data     = '0;
        stall_mode    = STALL_NONE;
        gaps_on       = 1'b0;
        max_gap       = 3;
        burst_left    = 0;
        hold_requests = 0;
        items_sent    = 0;
        frames_sent   = 0;
        board = new();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames against the reset addresses.
        // Two-byte ack: too short, yet the type still shows.
        send_frame(make_frame(16'h0002, 8'h00, 16'h0000, 64'h0, 2), 1'b0);
        // Sequence record ignores the last marker.
        send_item(FUNC_TX_SEQ, 8'h5A, 1'b1);
        // Bare ack that matches the recorded sequence.
        send_frame(make_frame(16'h0002, 8'h5A, 16'h0000, 64'h0, 3), 1'b0);
        // Reserved destination mode with ack request: rejected.
        send_frame(make_frame(16'h0461, 8'hFF, 16'h0000, 64'h0, 3), 1'b0);
        // Short destination mode, broadcast PAN, ack request.
        send_frame(make_frame(16'h8861, 8'h00, 16'hFFFF, 64'h0, 5), 1'b0);
        // Extended destination on a foreign PAN, address equals own (zero).
        send_frame(make_frame(16'hCC21, 8'hA5, 16'h1234, 64'h0, 13), 1'b0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0) begin
                wait_idle();
                case (phase)
                    1: begin
                        write_register(CFG_OWN_PAN,   {32'($urandom), 16'($urandom), 16'h0000});
                        write_register(CFG_OWN_SHORT, {32'($urandom), 16'($urandom), 16'h0000});
                        write_register(CFG_OWN_EXT,   64'h0);
                    end
                    2: begin
                        write_register(CFG_OWN_PAN,   {32'($urandom), 16'($urandom), 16'hFFFE});
                        write_register(CFG_OWN_SHORT, {32'($urandom), 16'($urandom), 16'hFFFF});
                        write_register(CFG_OWN_EXT,   {64{1'b1}});
                    end
                    default: begin
                        write_register(CFG_OWN_PAN,   {32'($urandom), 32'($urandom)});
                        write_register(CFG_OWN_SHORT, {32'($urandom), 32'($urandom)});
                        write_register(CFG_OWN_EXT,   {32'($urandom), 32'($urandom)});
                    end
                endcase
            end

            if (phase == NUM_PHASES - 1) begin
                // Back-to-back short frames into a receiver that holds off,
                // so the frame queue fills and the input stalls.
                gaps_on = 1'b0;
                stall_mode = STALL_NONE;
                hold_requests++;
                repeat (24)
                    send_frame(make_frame(16'($urandom) & ~DST_MODE_MASK, 8'($urandom),
                                          16'h0, 64'h0, 3), 1'b0);
            end

            stall_mode = t_stall_mode'($urandom_range(0, 3));
            gaps_on    = 1'b1;
            phase_end  = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                // reshuffle idling now and then, including stretches with none
                if ($urandom_range(0, 7) == 0) begin
                    stall_mode = t_stall_mode'($urandom_range(0, 3));
                    gaps_on    = $urandom_range(0, 2) != 0;
                    max_gap    = $urandom_range(1, 6);
                end
                send_random_frame();
            end
        end

        in_valid <= 1'b0;
        drain_cycles = 0;
        while (board.verdicts.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(negedge clk);
            drain_cycles++;
        end
        if (board.verdicts.size() != 0) begin
            $error("%0d frame verdicts never delivered", board.verdicts.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            repeat (SETTLE_CYCLES) @(negedge clk);
            $display("Sent %0d items in %0d frames over %0d address settings, one long hold-off.",
                     items_sent, frames_sent, NUM_PHASES);
            $display("Checked %0d verdicts: %0d accepted, %0d ack matches, %0d ack requests.",
                     board.n_results, board.n_accepted, board.n_matched, board.n_ack_requests);
            if (board.n_errors == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
            $finish;
        end
    end

endmodule

// ===== frame_destination_filter_unit.f =====
rtl/fdf_pkg.sv
rtl/fdf_front.sv
rtl/fdf_queue.sv
rtl/fdf_back.sv
rtl/frame_destination_filter_unit.sv
rtl/fdf_checker.sv
dv/tb_frame_destination_filter_unit.sv
